// ===== rtl/small_prime_table_factorizer_unit_macros.svh =====
// assertion macros for the small prime table factoriser checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef SMALL_PRIME_TABLE_FACTORIZER_UNIT_MACROS_SVH
`define SMALL_PRIME_TABLE_FACTORIZER_UNIT_MACROS_SVH

// concurrent check, switched off while reset is held
`define SPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// concurrent check that also covers the reset cycles
`define SPT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/spt_pkg.sv =====
// shared types, constants, prime table and microcode for the factoriser
// no dependencies; used by every rtl file of the block except the macro header
package spt_pkg;

    // field widths
    localparam int NUM_W       = 64;
    localparam int EXP_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int PRIME_W     = 10;
    localparam int FULL_TABLE  = 100;
    localparam int IDX_W       = $clog2(FULL_TABLE);
    localparam int OUT_TDATA_W = ((NUM_W + EXP_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 1 + STATUS_W + 1;

    // divider: one digit of the dividend per cycle
    localparam int DIGIT_W   = 8;
    localparam int DIV_STEPS = NUM_W / DIGIT_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_FACTOR = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ONE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO   = 2'd2;

    // first hundred primes
    localparam logic [PRIME_W-1:0] PRIME_ROM [FULL_TABLE] = '{
        10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,  10'd23,  10'd29,
        10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,  10'd59,  10'd61,  10'd67,  10'd71,
        10'd73,  10'd79,  10'd83,  10'd89,  10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113,
        10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
        10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223, 10'd227, 10'd229,
        10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269, 10'd271, 10'd277, 10'd281,
        10'd283, 10'd293, 10'd307, 10'd311, 10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349,
        10'd353, 10'd359, 10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
        10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463,
        10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541
    };

    // table read, indexes past the end give zero
    function automatic logic [PRIME_W-1:0] prime_at(input logic [IDX_W-1:0] i);
        logic [PRIME_W-1:0] p;
        p = '0;
        if (i < IDX_W'(FULL_TABLE)) begin
            p = PRIME_ROM[i];
        end
        return p;
    endfunction

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_START,
        OP_TAKE_QUOT,
        OP_PUSH_PRIME,
        OP_NEXT_PRIME,
        OP_PUSH_LEFT,
        OP_FINAL,
        OP_EMIT_ZERO,
        OP_EMIT_ONE
    } op_t;

    // what a step waits for before it executes
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT,
        HOLD_DIV
    } hold_t;

    // branch conditions
    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_N_ZERO,
        CND_N_ONE,
        CND_N_GT1,
        CND_REM_ZERO,
        CND_REM_NZ,
        CND_MORE
    } cond_t;

    localparam int PC_W = 4;

    typedef struct packed {
        op_t               op;
        hold_t             hold;
        cond_t             cond;
        logic [PC_W-1:0]   target;
    } uword_t;

    // flags from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_busy;
        logic n_zero;
        logic n_one;
        logic n_gt1;
        logic rem_zero;
        logic more_trials;
    } seq_status_t;

    // controls from the sequencer to the datapath
    typedef struct packed {
        logic op_en;
        op_t  op;
        logic in_ready;
    } seq_ctrl_t;

    // program addresses
    localparam logic [PC_W-1:0] A_FETCH  = 4'd0;
    localparam logic [PC_W-1:0] A_CHK0   = 4'd1;
    localparam logic [PC_W-1:0] A_CHK1   = 4'd2;
    localparam logic [PC_W-1:0] A_TRIAL  = 4'd3;
    localparam logic [PC_W-1:0] A_TEST   = 4'd4;
    localparam logic [PC_W-1:0] A_HIT    = 4'd5;
    localparam logic [PC_W-1:0] A_REDIV  = 4'd6;
    localparam logic [PC_W-1:0] A_RETEST = 4'd7;
    localparam logic [PC_W-1:0] A_PUSH   = 4'd8;
    localparam logic [PC_W-1:0] A_NEXTP  = 4'd9;
    localparam logic [PC_W-1:0] A_TAIL   = 4'd10;
    localparam logic [PC_W-1:0] A_FINAL  = 4'd11;
    localparam logic [PC_W-1:0] A_LEFT   = 4'd12;
    localparam logic [PC_W-1:0] A_ZERO   = 4'd13;
    localparam logic [PC_W-1:0] A_ONE    = 4'd14;

    function automatic uword_t mk_uword(input op_t op, input hold_t hold, input cond_t cond,
                                        input logic [PC_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.hold   = hold;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // control store
    function automatic uword_t urom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            A_FETCH:  w = mk_uword(OP_LOAD,       HOLD_IN,   CND_NEVER,    A_FETCH);
            A_CHK0:   w = mk_uword(OP_NOP,        HOLD_NONE, CND_N_ZERO,   A_ZERO);
            A_CHK1:   w = mk_uword(OP_NOP,        HOLD_NONE, CND_N_ONE,    A_ONE);
            A_TRIAL:  w = mk_uword(OP_DIV_START,  HOLD_NONE, CND_NEVER,    A_FETCH);
            A_TEST:   w = mk_uword(OP_NOP,        HOLD_DIV,  CND_REM_NZ,   A_NEXTP);
            A_HIT:    w = mk_uword(OP_TAKE_QUOT,  HOLD_NONE, CND_NEVER,    A_FETCH);
            A_REDIV:  w = mk_uword(OP_DIV_START,  HOLD_NONE, CND_NEVER,    A_FETCH);
            A_RETEST: w = mk_uword(OP_NOP,        HOLD_DIV,  CND_REM_ZERO, A_HIT);
            A_PUSH:   w = mk_uword(OP_PUSH_PRIME, HOLD_OUT,  CND_NEVER,    A_FETCH);
            A_NEXTP:  w = mk_uword(OP_NEXT_PRIME, HOLD_NONE, CND_MORE,     A_TRIAL);
            A_TAIL:   w = mk_uword(OP_NOP,        HOLD_NONE, CND_N_GT1,    A_LEFT);
            A_FINAL:  w = mk_uword(OP_FINAL,      HOLD_OUT,  CND_ALWAYS,   A_FETCH);
            A_LEFT:   w = mk_uword(OP_PUSH_LEFT,  HOLD_OUT,  CND_ALWAYS,   A_FINAL);
            A_ZERO:   w = mk_uword(OP_EMIT_ZERO,  HOLD_OUT,  CND_ALWAYS,   A_FETCH);
            A_ONE:    w = mk_uword(OP_EMIT_ONE,   HOLD_OUT,  CND_ALWAYS,   A_FETCH);
            default:  w = mk_uword(OP_NOP,        HOLD_NONE, CND_ALWAYS,   A_FETCH);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/spt_divider.sv =====
// iterative divider of the 64-bit cofactor by a table prime
// one digit of the dividend per cycle; depends on spt_pkg
module spt_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [spt_pkg::NUM_W-1:0]     dividend,
    input  logic [spt_pkg::PRIME_W-1:0]   divisor,
    output logic                          busy,
    output logic [spt_pkg::NUM_W-1:0]     quotient,
    output logic                          rem_zero
);

    logic [spt_pkg::NUM_W-1:0]   dq_reg,   dq_next;
    logic [spt_pkg::PRIME_W-1:0] rem_reg,  rem_next;
    logic [spt_pkg::PRIME_W-1:0] dvs_reg,  dvs_next;
    logic [spt_pkg::DCNT_W-1:0]  cnt_reg,  cnt_next;
    logic                        busy_reg, busy_next;

    logic [spt_pkg::PRIME_W-1:0] step_rem;
    logic [spt_pkg::PRIME_W:0]   step_t;
    logic [spt_pkg::DIGIT_W-1:0] step_q;

    // restoring division over one digit
    always_comb begin
        step_rem = rem_reg;
        step_q   = '0;
        step_t   = '0;
        for (int k = 0; k < spt_pkg::DIGIT_W; k++) begin
            step_t = {step_rem, dq_reg[spt_pkg::NUM_W-1-k]};
            if (step_t >= {1'b0, dvs_reg}) begin
                step_t = step_t - {1'b0, dvs_reg};
                step_q[spt_pkg::DIGIT_W-1-k] = 1'b1;
            end
            step_rem = step_t[spt_pkg::PRIME_W-1:0];
        end
    end

    // dividend shifts out at the top while quotient digits enter at the bottom
    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dq_next  = {dq_reg[spt_pkg::NUM_W-spt_pkg::DIGIT_W-1:0], step_q};
            rem_next = step_rem;
            cnt_next = cnt_reg + spt_pkg::DCNT_W'(1);
            if (cnt_reg == spt_pkg::DCNT_W'(spt_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ===== rtl/spt_sequencer.sv =====
// microcoded sequencer: step counter, control store and branch logic
// depends on spt_pkg for the control word and the status and control structs
module spt_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spt_pkg::seq_status_t status,
    output spt_pkg::seq_ctrl_t   ctrl
);

    logic [spt_pkg::PC_W-1:0] pc_reg, pc_next;
    spt_pkg::uword_t          uw;
    logic                     go;
    logic                     taken;

    assign uw = spt_pkg::urom(pc_reg);

    // a step runs once what it waits for is there
    always_comb begin
        case (uw.hold)
            spt_pkg::HOLD_NONE: go = 1'b1;
            spt_pkg::HOLD_IN:   go = status.in_valid;
            spt_pkg::HOLD_OUT:  go = status.out_free;
            spt_pkg::HOLD_DIV:  go = !status.div_busy;
            default:            go = 1'b0;
        endcase
    end

    // branch condition
    always_comb begin
        case (uw.cond)
            spt_pkg::CND_NEVER:    taken = 1'b0;
            spt_pkg::CND_ALWAYS:   taken = 1'b1;
            spt_pkg::CND_N_ZERO:   taken = status.n_zero;
            spt_pkg::CND_N_ONE:    taken = status.n_one;
            spt_pkg::CND_N_GT1:    taken = status.n_gt1;
            spt_pkg::CND_REM_ZERO: taken = status.rem_zero;
            spt_pkg::CND_REM_NZ:   taken = !status.rem_zero;
            spt_pkg::CND_MORE:     taken = status.more_trials;
            default:               taken = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        pc_next = pc_reg;
        if (go) begin
            pc_next = taken ? uw.target : pc_reg + spt_pkg::PC_W'(1);
        end
    end

    // controls to the datapath
    always_comb begin
        ctrl.op_en    = go;
        ctrl.op       = uw.op;
        ctrl.in_ready = (uw.op == spt_pkg::OP_LOAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= spt_pkg::A_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/small_prime_table_factorizer_unit.sv =====
// top level of the small prime table factoriser: datapath and output word register
// depends on spt_pkg, spt_sequencer and spt_divider
//
// usage
//   input channel s_*: one word per number to factor, s_tdata holds the 64-bit value.
//   result channel m_*: one word per factor found, ascending primes first, then any
//   cofactor left over (not in the table). m_tlast marks the final word for a number;
//   m_tuser bit 3 on that word is set when every factor came from the table.
//   an input of one gives a single word with status one, an input of zero a single
//   word with status zero.
// timing
//   zero and one: checked in the steps after acceptance; the status word is written once
//   the output register is free. otherwise one division per table prime tried, plus one
//   more for each time a prime divides; the divider handles 8 dividend bits per cycle.
//   one number is processed at a time; the next one is taken as soon as the final
//   word sits in the output register.
// reset and stall
//   aresetn is synchronous, active low; it empties the output register and returns
//   the sequencer to its fetch step. a stalled receiver holds the output word and
//   the sequencer waits at the next step that pushes or writes a word.
module small_prime_table_factorizer_unit #(
    parameter int TABLE_PRIMES = 100
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: number [63:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spt_pkg::NUM_W-1:0]         s_tdata,
    // m_tdata: factor [63:0], exponent [69:64], zero pad [71:70]
    // m_tuser: in_table [0], status [2:1], all_in_table [3]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [spt_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [spt_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                              m_tlast
);

    localparam int LIMIT = (TABLE_PRIMES > spt_pkg::FULL_TABLE) ? spt_pkg::FULL_TABLE
                                                                : TABLE_PRIMES;

    spt_pkg::seq_status_t seq_status;
    spt_pkg::seq_ctrl_t   ctrl;

    logic                          div_start;
    logic                          div_busy;
    logic                          div_rem_zero;
    logic [spt_pkg::NUM_W-1:0]     div_quot;
    logic [spt_pkg::PRIME_W-1:0]   cur_prime;

    // working registers
    logic [spt_pkg::NUM_W-1:0]     n_reg,   n_next;
    logic [spt_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [spt_pkg::EXP_W-1:0]     exp_reg, exp_next;
    logic                          all_reg, all_next;

    // pending result, sent once it is known whether it is the last
    logic                          pend_valid_reg,    pend_valid_next;
    logic [spt_pkg::NUM_W-1:0]     pend_factor_reg,   pend_factor_next;
    logic [spt_pkg::EXP_W-1:0]     pend_exp_reg,      pend_exp_next;
    logic                          pend_in_table_reg, pend_in_table_next;

    // output word register
    logic                          out_valid_reg,    out_valid_next;
    logic [spt_pkg::NUM_W-1:0]     out_factor_reg,   out_factor_next;
    logic [spt_pkg::EXP_W-1:0]     out_exp_reg,      out_exp_next;
    logic                          out_in_table_reg, out_in_table_next;
    logic [spt_pkg::STATUS_W-1:0]  out_status_reg,   out_status_next;
    logic                          out_all_reg,      out_all_next;
    logic                          out_last_reg,     out_last_next;
    logic                          out_write;

    assign cur_prime = spt_pkg::prime_at(idx_reg);

    spt_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (seq_status),
        .ctrl    (ctrl)
    );

    spt_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (cur_prime),
        .busy     (div_busy),
        .quotient (div_quot),
        .rem_zero (div_rem_zero)
    );

    // flags for the sequencer
    always_comb begin
        seq_status.in_valid    = s_tvalid;
        seq_status.out_free    = !out_valid_reg || m_tready;
        seq_status.div_busy    = div_busy;
        seq_status.n_zero      = (n_reg == '0);
        seq_status.n_one       = (n_reg == spt_pkg::NUM_W'(1));
        seq_status.n_gt1       = (n_reg[spt_pkg::NUM_W-1:1] != '0);
        seq_status.rem_zero    = div_rem_zero;
        seq_status.more_trials = (idx_reg != spt_pkg::IDX_W'(LIMIT - 1))
                                 && (n_reg[spt_pkg::NUM_W-1:1] != '0);
    end

    // datapath operations
    always_comb begin
        n_next             = n_reg;
        idx_next           = idx_reg;
        exp_next           = exp_reg;
        all_next           = all_reg;
        pend_valid_next    = pend_valid_reg;
        pend_factor_next   = pend_factor_reg;
        pend_exp_next      = pend_exp_reg;
        pend_in_table_next = pend_in_table_reg;
        out_factor_next    = out_factor_reg;
        out_exp_next       = out_exp_reg;
        out_in_table_next  = out_in_table_reg;
        out_status_next    = out_status_reg;
        out_all_next       = out_all_reg;
        out_last_next      = out_last_reg;
        out_write          = 1'b0;
        div_start          = 1'b0;
        if (ctrl.op_en) begin
            case (ctrl.op)
                spt_pkg::OP_LOAD: begin
                    n_next          = s_tdata;
                    idx_next        = '0;
                    exp_next        = '0;
                    all_next        = 1'b1;
                    pend_valid_next = 1'b0;
                end
                spt_pkg::OP_DIV_START: begin
                    div_start = 1'b1;
                end
                spt_pkg::OP_TAKE_QUOT: begin
                    n_next   = div_quot;
                    exp_next = exp_reg + spt_pkg::EXP_W'(1);
                end
                spt_pkg::OP_PUSH_PRIME, spt_pkg::OP_PUSH_LEFT: begin
                    // the previous result is now known not to be the last
                    if (pend_valid_reg) begin
                        out_write         = 1'b1;
                        out_factor_next   = pend_factor_reg;
                        out_exp_next      = pend_exp_reg;
                        out_in_table_next = pend_in_table_reg;
                        out_status_next   = spt_pkg::STATUS_FACTOR;
                        out_all_next      = 1'b0;
                        out_last_next     = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    if (ctrl.op == spt_pkg::OP_PUSH_PRIME) begin
                        pend_factor_next   = spt_pkg::NUM_W'(cur_prime);
                        pend_exp_next      = exp_reg;
                        pend_in_table_next = 1'b1;
                    end else begin
                        pend_factor_next   = n_reg;
                        pend_exp_next      = spt_pkg::EXP_W'(1);
                        pend_in_table_next = 1'b0;
                        all_next           = 1'b0;
                    end
                end
                spt_pkg::OP_NEXT_PRIME: begin
                    idx_next = idx_reg + spt_pkg::IDX_W'(1);
                    exp_next = '0;
                end
                spt_pkg::OP_FINAL: begin
                    out_write         = 1'b1;
                    out_factor_next   = pend_factor_reg;
                    out_exp_next      = pend_exp_reg;
                    out_in_table_next = pend_in_table_reg;
                    out_status_next   = spt_pkg::STATUS_FACTOR;
                    out_all_next      = all_reg;
                    out_last_next     = 1'b1;
                    pend_valid_next   = 1'b0;
                end
                spt_pkg::OP_EMIT_ZERO, spt_pkg::OP_EMIT_ONE: begin
                    out_write         = 1'b1;
                    out_factor_next   = '0;
                    out_exp_next      = '0;
                    out_in_table_next = 1'b0;
                    out_last_next     = 1'b1;
                    if (ctrl.op == spt_pkg::OP_EMIT_ZERO) begin
                        out_status_next = spt_pkg::STATUS_ZERO;
                        out_all_next    = 1'b0;
                    end else begin
                        out_status_next = spt_pkg::STATUS_ONE;
                        out_all_next    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output word handshake
    always_comb begin
        if (out_write) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        n_reg             <= n_next;
        idx_reg           <= idx_next;
        exp_reg           <= exp_next;
        all_reg           <= all_next;
        pend_factor_reg   <= pend_factor_next;
        pend_exp_reg      <= pend_exp_next;
        pend_in_table_reg <= pend_in_table_next;
        out_factor_reg    <= out_factor_next;
        out_exp_reg       <= out_exp_next;
        out_in_table_reg  <= out_in_table_next;
        out_status_reg    <= out_status_next;
        out_all_reg       <= out_all_next;
        out_last_reg      <= out_last_next;
    end

    assign s_tready = ctrl.in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(spt_pkg::OUT_TDATA_W - spt_pkg::NUM_W - spt_pkg::EXP_W)'(0),
                       out_exp_reg, out_factor_reg};
    assign m_tuser  = {out_all_reg, out_status_reg, out_in_table_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/spt_checker.sv =====
// port-level checks on the factoriser, bound to the top level
// depends on spt_pkg and small_prime_table_factorizer_unit_macros.svh
`include "small_prime_table_factorizer_unit_macros.svh"

module spt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [spt_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic [spt_pkg::OUT_TUSER_W-1:0]   m_tuser,
    input logic                              m_tlast
);

    logic open_reg, open_next;
    logic s_word;
    logic m_last_word;
    logic m_stall;
    logic m_special;
    logic [spt_pkg::OUT_TDATA_W+spt_pkg::OUT_TUSER_W:0] m_word;

    assign s_word      = s_tvalid && s_tready;
    assign m_last_word = m_tvalid && m_tlast;
    assign m_stall     = m_tvalid && !m_tready;
    assign m_special   = m_tvalid && (m_tuser[2:1] != spt_pkg::STATUS_FACTOR);
    assign m_word      = {m_tlast, m_tuser, m_tdata};

    // a number is open from acceptance until its final word shows
    always_comb begin
        if (s_word) begin
            open_next = 1'b1;
        end else if (m_last_word) begin
            open_next = 1'b0;
        end else begin
            open_next = open_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
        end else begin
            open_reg <= open_next;
        end
    end

    // reset empties the output register
    `SPT_ASSERT_RST(a_reset_idle, (!aresetn |=> !m_tvalid), "output valid after reset")

    // a stalled word holds
    `SPT_ASSERT(a_stall_hold, (m_stall |=> m_tvalid && $stable(m_word)), "stalled word changed")

    // no new number while the current one has not produced its final word
    `SPT_ASSERT(a_one_at_a_time, (open_reg && !m_last_word |-> !s_tready), "input taken mid-run")

    // special cases carry no factor and end the run
    `SPT_ASSERT(a_special_word, (m_special |-> m_tlast && m_tdata == '0), "bad special word")

    // the all-in-table flag appears only on the final word
    `SPT_ASSERT(a_all_on_last, (m_tvalid && m_tuser[3] |-> m_tlast), "flag before last word")

endmodule

bind small_prime_table_factorizer_unit spt_checker u_spt_checker (.*);

// ===== dv/small_prime_table_factorizer_unit_checker.sv =====
// result checker for the small prime table factoriser: watches both stream channels
// predicts the factor words of every accepted number and compares them in order
// depends on spt_pkg for widths and status codes
module small_prime_table_factorizer_unit_checker #(
    parameter int TABLE_PRIMES = 100
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: number [63:0]
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [spt_pkg::NUM_W-1:0]       s_tdata,
    // m_tdata: factor [63:0], exponent [69:64], zero pad [71:70]
    // m_tuser: in_table [0], status [2:1], all_in_table [3]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [spt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [spt_pkg::OUT_TUSER_W-1:0] m_tuser,
    input  logic                            m_tlast,
    output int                              mismatch_count,
    output int                              outstanding
);

    localparam int TRIALS      = (TABLE_PRIMES > 100) ? 100 : TABLE_PRIMES;
    localparam int MAX_WORDS   = 15;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [spt_pkg::NUM_W-1:0]    factor;
        logic [spt_pkg::EXP_W-1:0]    exponent;
        logic                         in_table;
        logic [spt_pkg::STATUS_W-1:0] status;
        logic                         all_in_table;
        logic                         last;
    } factor_word_t;

    int unsigned  trial_primes [100];
    factor_word_t expected_factors [$];

    // first hundred primes, found by plain trial at start of run
    initial begin : build_trial_primes
        int          found;
        int unsigned cand;
        bit          is_prime;
        found = 0;
        cand  = 2;
        while (found < 100) begin
            is_prime = 1'b1;
            for (int unsigned d = 2; d * d <= cand; d++) begin
                if (cand % d == 0) begin
                    is_prime = 1'b0;
                end
            end
            if (is_prime) begin
                trial_primes[found] = cand;
                found++;
            end
            cand++;
        end
    end

    // trial division of one number, queues the words it should give
    function automatic void predict_factors(input logic [spt_pkg::NUM_W-1:0] number);
        factor_word_t              words [$];
        factor_word_t              w;
        logic [spt_pkg::NUM_W-1:0] rest;
        logic [spt_pkg::NUM_W-1:0] p;
        int                        mult;
        int                        i;
        bit                        only_table;
        rest       = number;
        only_table = 1'b1;
        w          = '0;
        if (number == 0) begin
            w.status = spt_pkg::STATUS_ZERO;
            w.last   = 1'b1;
            words.push_back(w);
        end else if (number == 1) begin
            w.status       = spt_pkg::STATUS_ONE;
            w.all_in_table = 1'b1;
            w.last         = 1'b1;
            words.push_back(w);
        end else begin
            for (i = 0; i < TRIALS && rest > 1; i++) begin
                p = spt_pkg::NUM_W'(trial_primes[i]);
                if (rest % p == 0) begin
                    mult = 0;
                    while (rest % p == 0) begin
                        mult++;
                        rest = rest / p;
                    end
                    if (words.size() < MAX_WORDS) begin
                        w          = '0;
                        w.factor   = p;
                        w.exponent = spt_pkg::EXP_W'(mult);
                        w.in_table = 1'b1;
                        w.status   = spt_pkg::STATUS_FACTOR;
                        words.push_back(w);
                    end
                end
            end
            // leftover cofactor, prime or not, goes out as one word
            if (rest > 1) begin
                only_table = 1'b0;
                if (words.size() < MAX_WORDS) begin
                    w          = '0;
                    w.factor   = rest;
                    w.exponent = spt_pkg::EXP_W'(1);
                    w.status   = spt_pkg::STATUS_FACTOR;
                    words.push_back(w);
                end
            end
            words[words.size() - 1].all_in_table = only_table;
            words[words.size() - 1].last         = 1'b1;
        end
        foreach (words[k]) begin
            expected_factors.push_back(words[k]);
        end
    endfunction

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    // predict on every accepted number, compare every accepted word
    always @(posedge aclk) begin : watch_channels
        factor_word_t got;
        factor_word_t want;
        bit           bad;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_factors(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got.factor       = m_tdata[spt_pkg::NUM_W-1:0];
                got.exponent     = m_tdata[spt_pkg::NUM_W +: spt_pkg::EXP_W];
                got.in_table     = m_tuser[0];
                got.status       = m_tuser[2:1];
                got.all_in_table = m_tuser[3];
                got.last         = m_tlast;
                if (expected_factors.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT) begin
                        $display("%0t: unexpected word factor %0d exponent %0d in_table %0b",
                                 $time, got.factor, got.exponent, got.in_table,
                                 " status %0d all_in_table %0b last %0b",
                                 got.status, got.all_in_table, got.last);
                    end
                end else begin
                    want = expected_factors.pop_front();
                    bad  = (got.factor !== want.factor) || (got.exponent !== want.exponent)
                        || (got.in_table !== want.in_table) || (got.status !== want.status)
                        || (got.all_in_table !== want.all_in_table) || (got.last !== want.last);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_LIMIT) begin
                            $display("%0t: word mismatch, expected factor %0d exponent %0d",
                                     $time, want.factor, want.exponent,
                                     " in_table %0b status %0d all_in_table %0b last %0b",
                                     want.in_table, want.status, want.all_in_table, want.last);
                            $display("%0t:                  got factor %0d exponent %0d",
                                     $time, got.factor, got.exponent,
                                     " in_table %0b status %0d all_in_table %0b last %0b",
                                     got.in_table, got.status, got.all_in_table, got.last);
                        end
                    end
                end
            end
        end
        outstanding <= expected_factors.size();
    end

endmodule

// ===== dv/small_prime_table_factorizer_unit_tb.sv =====
// testbench top for the small prime table factoriser: clock, reset, number stimulus,
// result sink with back-pressure, watchdog and verdict
// depends on spt_pkg, the block and small_prime_table_factorizer_unit_checker
module small_prime_table_factorizer_unit_tb;

    localparam int TABLE_PRIMES     = 100;
    localparam int RANDOM_PER_PHASE = 144;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int QUIET_LIMIT      = 20000;
    localparam int SETTLE_CYCLES    = 2000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [spt_pkg::NUM_W-1:0]       s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [spt_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [spt_pkg::OUT_TUSER_W-1:0] m_tuser;
    logic                            m_tlast;

    int mismatch_count;
    int outstanding;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests = 0;
    int holds_served  = 0;
    int quiet_cycles  = 0;

    // 20 unit clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    small_prime_table_factorizer_unit #(
        .TABLE_PRIMES (TABLE_PRIMES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    small_prime_table_factorizer_unit_checker #(
        .TABLE_PRIMES (TABLE_PRIMES)
    ) factor_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // random number mix: smooth numbers that finish early as the largest share, plus
    // leftover cofactors, raw 64-bit values, tiny values and prime powers
    function automatic logic [63:0] draw_number();
        logic [63:0] n;
        int unsigned v;
        int unsigned pick;
        int unsigned count;
        pick = $urandom_range(99);
        n    = 64'd1;
        if (pick < 40) begin
            count = $urandom_range(1, 10);
            repeat (count) begin
                v = $urandom_range(2, 541);
                if (n <= ALL_ONES / 64'(v)) begin
                    n = n * 64'(v);
                end
            end
        end else if (pick < 60) begin
            n     = 64'($urandom_range(542, 1 << 20));
            count = $urandom_range(0, 5);
            repeat (count) begin
                v = $urandom_range(2, 541);
                if (n <= ALL_ONES / 64'(v)) begin
                    n = n * 64'(v);
                end
            end
        end else if (pick < 85) begin
            n = {$urandom, $urandom};
        end else if (pick < 95) begin
            n = 64'($urandom_range(0, 600));
        end else begin
            v = $urandom_range(2, 541);
            n = 64'(v);
            while (n <= ALL_ONES / 64'(v) && $urandom_range(9) != 0) begin
                n = n * 64'(v);
            end
        end
        return n;
    endfunction

    // offer one number, with random idle cycles ahead of it
    task automatic send_number(input logic [63:0] number);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= number;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // stop offering until every predicted word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (outstanding != 0);
    endtask

    // result sink: random stalls, plus a long hold-off on request
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL small_prime_table_factorizer_unit");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [63:0] directed_numbers [$];
        logic [63:0] power_of_541;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tx_idle_pct = 33;
        rx_idle_pct = 54;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // zero, one, table edges, first prime past the table, composite
        // leftover, top exponent, all-ones and largest 64-bit prime
        power_of_541 = 64'd1;
        repeat (7) power_of_541 = power_of_541 * 64'd541;
        directed_numbers = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd6, 64'd1024,
            64'd541, 64'd542, 64'd547, 64'd299209, 64'd591854,
            64'h8000_0000_0000_0000, ALL_ONES, 64'hFFFF_FFFF_FFFF_FFC5,
            64'd12157665459056928801, 64'd614889782588491410
        };
        directed_numbers.push_back(power_of_541);
        foreach (directed_numbers[k]) begin
            send_number(directed_numbers[k]);
        end
        wait_drained();

        // three idling phases, the last with none
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 54 : 0;
            rx_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 33 : 0;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (phase == 0 && i == 20) begin
                    hold_requests++;
                end
                if (phase == 1 && i == 70) begin
                    wait_drained();
                end
                send_number(draw_number());
            end
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("PASS small_prime_table_factorizer_unit");
        end else begin
            $display("FAIL small_prime_table_factorizer_unit");
        end
        $finish;
    end

endmodule
